>>> design/lz10_pkg.sv
// Shared types and constants for the LZ10 decoder.
package lz10_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int BYTE_W       = 8;
    localparam int OUT_LEN_W    = 24;
    localparam int LEN_W        = 5;
    localparam int DIST_W       = 13;
    localparam int FLAG_CNT_W   = 4;
    localparam int LEN_BIAS     = 3;
    localparam int FLAG_TOKENS  = 8;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              stream_done;
        logic              bad_reference;
    } t_result;

endpackage

>>> design/lz10_ram.sv
// Generic simple dual-port RAM with registered read.
module lz10_ram #(
    parameter int WIDTH = lz10_pkg::BYTE_W,
    parameter int DEPTH = lz10_pkg::WINDOW_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/lz10_obuf.sv
// Output register between the decode core and the result stream.
module lz10_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  lz10_pkg::t_result i_push_data,
    output logic              o_valid,
    input  logic              i_ready,
    output lz10_pkg::t_result o_data
);

    logic              r_valid;
    lz10_pkg::t_result r_data;

    // Slot frees up in the same cycle its content transfers
    assign o_push_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_push_ready) begin
            r_valid <= i_push_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_push_ready && i_push_valid) begin
            r_data <= i_push_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> design/lz10_core.sv
// Token parser and copy sequencer working on the history RAM.
module lz10_core #(
    parameter int WINDOW_DEPTH = lz10_pkg::WINDOW_DEPTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [lz10_pkg::OUT_LEN_W-1:0]        i_out_length,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [lz10_pkg::BYTE_W-1:0]           i_in_byte,
    output logic                                  o_push_valid,
    input  logic                                  i_push_ready,
    output lz10_pkg::t_result                     o_push_data,
    output logic                                  o_wr_en,
    output logic [$clog2(WINDOW_DEPTH)-1:0]       o_wr_addr,
    output logic [lz10_pkg::BYTE_W-1:0]           o_wr_data,
    output logic                                  o_rd_en,
    output logic [$clog2(WINDOW_DEPTH)-1:0]       o_rd_addr,
    input  logic [lz10_pkg::BYTE_W-1:0]           i_rd_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW:0]   DepthExt = (AW+1)'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LastAddr = AW'(WINDOW_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PUSH = 4'b0010,
        ST_RD   = 4'b0100,
        ST_WR   = 4'b1000
    } t_state;

    t_state                                r_state, n_state;
    logic [AW-1:0]                         r_wp, n_wp;
    logic [AW-1:0]                         r_src, n_src;
    logic [lz10_pkg::OUT_LEN_W-1:0]        r_produced, n_produced;
    logic [lz10_pkg::BYTE_W-1:0]           r_flag, n_flag;
    logic [lz10_pkg::FLAG_CNT_W-1:0]       r_bits_left, n_bits_left;
    logic [lz10_pkg::BYTE_W-1:0]           r_pair_first, n_pair_first;
    logic                                  r_awaiting, n_awaiting;
    logic                                  r_halted, n_halted;
    logic [lz10_pkg::LEN_W-1:0]            r_len, n_len;
    lz10_pkg::t_result                     r_res, n_res;

    logic [lz10_pkg::LEN_W-1:0]            len_raw;
    logic [lz10_pkg::DIST_W-1:0]           ref_dist;
    logic [lz10_pkg::OUT_LEN_W-1:0]        remain;
    logic [lz10_pkg::OUT_LEN_W-1:0]        produced_inc;
    logic                                  done_next;
    logic [AW:0]                           src_diff;
    logic [AW:0]                           src_wrap;
    logic [AW-1:0]                         src_start;
    logic [AW-1:0]                         wp_inc;
    logic [AW-1:0]                         src_inc;
    logic                                  in_xfer;

    assign in_xfer      = i_in_valid && o_in_ready;
    assign len_raw      = {1'b0, r_pair_first[7:4]} + lz10_pkg::LEN_W'(lz10_pkg::LEN_BIAS);
    assign ref_dist     = {1'b0, r_pair_first[3:0], i_in_byte} + lz10_pkg::DIST_W'(1);
    assign remain       = i_out_length - r_produced;
    assign produced_inc = r_produced + lz10_pkg::OUT_LEN_W'(1);
    assign done_next    = (produced_inc == i_out_length);
    assign src_diff     = {1'b0, r_wp} - (AW+1)'(ref_dist);
    assign src_wrap     = src_diff + DepthExt;
    // Borrow means the source sits behind the wrap point
    assign src_start    = src_diff[AW] ? src_wrap[AW-1:0] : src_diff[AW-1:0];
    assign wp_inc       = (r_wp == LastAddr) ? '0 : r_wp + 1'b1;
    assign src_inc      = (r_src == LastAddr) ? '0 : r_src + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_wp         = r_wp;
        n_src        = r_src;
        n_produced   = r_produced;
        n_flag       = r_flag;
        n_bits_left  = r_bits_left;
        n_pair_first = r_pair_first;
        n_awaiting   = r_awaiting;
        n_halted     = r_halted;
        n_len        = r_len;
        n_res        = r_res;
        o_in_ready   = 1'b0;
        o_push_valid = 1'b0;
        o_push_data  = r_res;
        o_wr_en      = 1'b0;
        o_wr_data    = i_in_byte;
        o_rd_en      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer && !r_halted && (r_produced < i_out_length)) begin
                    if (r_bits_left == '0) begin
                        n_flag      = i_in_byte;
                        n_bits_left = lz10_pkg::FLAG_CNT_W'(lz10_pkg::FLAG_TOKENS);
                    end else if (!r_flag[7]) begin
                        // literal: store now, hand result over next
                        o_wr_en     = 1'b1;
                        n_wp        = wp_inc;
                        n_produced  = produced_inc;
                        n_res       = '{out_byte: i_in_byte, last_of_run: 1'b1,
                                        stream_done: done_next, bad_reference: 1'b0};
                        n_flag      = {r_flag[6:0], 1'b0};
                        n_bits_left = r_bits_left - 1'b1;
                        n_state     = ST_PUSH;
                    end else if (!r_awaiting) begin
                        n_pair_first = i_in_byte;
                        n_awaiting   = 1'b1;
                    end else begin
                        n_awaiting  = 1'b0;
                        n_flag      = {r_flag[6:0], 1'b0};
                        n_bits_left = r_bits_left - 1'b1;
                        if (lz10_pkg::OUT_LEN_W'(ref_dist) > r_produced) begin
                            n_halted = 1'b1;
                            n_res    = '{out_byte: '0, last_of_run: 1'b1,
                                         stream_done: 1'b0, bad_reference: 1'b1};
                            n_state  = ST_PUSH;
                        end else begin
                            // clip the copy to what is left of the stream
                            n_len   = (lz10_pkg::OUT_LEN_W'(len_raw) > remain)
                                      ? remain[lz10_pkg::LEN_W-1:0] : len_raw;
                            n_src   = src_start;
                            n_state = ST_RD;
                        end
                    end
                end
            end
            ST_PUSH: begin
                o_push_valid = 1'b1;
                if (i_push_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                o_rd_en = 1'b1;
                n_state = ST_WR;
            end
            ST_WR: begin
                // read data holds until the next read, so wait here on a stall
                o_push_valid = 1'b1;
                o_push_data  = '{out_byte: i_rd_data,
                                 last_of_run: (r_len == lz10_pkg::LEN_W'(1)),
                                 stream_done: done_next, bad_reference: 1'b0};
                o_wr_data    = i_rd_data;
                if (i_push_ready) begin
                    o_wr_en    = 1'b1;
                    n_wp       = wp_inc;
                    n_src      = src_inc;
                    n_produced = produced_inc;
                    n_len      = r_len - 1'b1;
                    n_state    = (r_len == lz10_pkg::LEN_W'(1)) ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_wr_addr = r_wp;
    assign o_rd_addr = r_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_wp         <= '0;
            r_produced   <= '0;
            r_flag       <= '0;
            r_bits_left  <= '0;
            r_pair_first <= '0;
            r_awaiting   <= 1'b0;
            r_halted     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wp         <= n_wp;
            r_produced   <= n_produced;
            r_flag       <= n_flag;
            r_bits_left  <= n_bits_left;
            r_pair_first <= n_pair_first;
            r_awaiting   <= n_awaiting;
            r_halted     <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src <= n_src;
        r_len <= n_len;
        r_res <= n_res;
    end

endmodule

>>> design/lz10_lzss_decoder.sv
// Top level of the LZ10 decoder: length register, core, history RAM, output register.
//
//  channel   direction  signals                      transfers
//  s_axis    in         tvalid tready tdata[7:0]     one compressed byte
//  m_axis    out        tvalid tready tdata tlast    one decompressed byte or error
//                       tuser[1:0]
//  cfg       in         i_cfg_valid o_cfg_ready      total output length, 24 bit
//                       i_cfg_data[23:0]
//
// A flag byte or the first byte of a pair is taken in ST_IDLE; a literal is written to
// history in ST_IDLE and then emitted from ST_PUSH. A pair second byte starts a copy of
// up to 18 bytes: each byte is one RAM read in ST_RD and one write back and emit in ST_WR.
// Reset clears all control state; history is not cleared and needs no sweep.
// A stall on m_axis holds the core in place; s_axis is taken only between tokens.
module lz10_lzss_decoder #(
    parameter int WINDOW_DEPTH = lz10_pkg::WINDOW_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] in_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [7:0] out_byte
    output logic                                m_axis_tlast,
    output logic [1:0]                          m_axis_tuser,  // [0] stream_done, [1] bad_reference
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lz10_pkg::OUT_LEN_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [lz10_pkg::OUT_LEN_W-1:0] r_out_length;
    logic                           push_valid;
    logic                           push_ready;
    lz10_pkg::t_result              push_data;
    lz10_pkg::t_result              out_data;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [lz10_pkg::BYTE_W-1:0]    wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [lz10_pkg::BYTE_W-1:0]    rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_out_length <= i_cfg_data;
        end
    end

    lz10_core #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_out_length (r_out_length),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    lz10_ram #(
        .WIDTH (lz10_pkg::BYTE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lz10_obuf u_obuf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (out_data)
    );

    assign m_axis_tdata = out_data.out_byte;
    assign m_axis_tlast = out_data.last_of_run;
    assign m_axis_tuser = {out_data.bad_reference, out_data.stream_done};

endmodule

>>> design/lz10_chk.sv
// Port-level checker for the LZ10 decoder, bound to the top level.
module lz10_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_bad_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata == 8'h00 && m_axis_tlast && !m_axis_tuser[0])
        else $error("bad-reference result malformed");

    // the decoder halts after a bad reference
    a_bad_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[1] |=> !m_axis_tvalid)
        else $error("result after bad reference");

    // copies are clipped, so the final byte always closes its run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("stream done without end of run");

endmodule

bind lz10_lzss_decoder lz10_chk u_lz10_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
